/* rtl/ngga_pkg.sv */
// Shared constants, record types and helper functions of the GGA sentence parser.
package ngga_pkg;

  localparam int MAX_LINE_DEF    = 512;
  localparam int FRAC_DIGITS_DEF = 5;
  localparam int MAX_FIELDS      = 15;

  localparam int FIELD_W     = 4;
  localparam int WHOLE_W     = 17;
  localparam int WHOLE_EXT_W = WHOLE_W + 4;
  localparam int FRAC_W_MAX  = 20;
  localparam int FRAC_EXT_W  = FRAC_W_MAX + 4;
  localparam int FIX_W       = 8;
  localparam int FIX_EXT_W   = FIX_W + 4;
  localparam int LAT_W       = 31;
  localparam int LON_W       = 32;
  localparam int HDR_LEN     = 6;

  localparam logic [WHOLE_W-1:0] WHOLE_MAX = 17'd131071;
  localparam logic [FIX_W-1:0]   FIX_MAX   = 8'd255;

  localparam int LAT_LIMIT = 900000000;
  localparam int LON_LIMIT = 1800000000;

  // reciprocals for the constant divides in the converter
  localparam logic [12:0] RECIP100 = 13'd5242;       // floor(2^19/100), under-estimate
  localparam logic [28:0] RECIP15  = 29'd286331153;  // floor(2^32/15)

  localparam int CONV_STAGES = 8;
  localparam int QUEUE_DEPTH = 2;

  // characters
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_W      = 8'h57;

  // comma field numbers
  localparam logic [FIELD_W-1:0] FLD_LAT      = 4'd2;
  localparam logic [FIELD_W-1:0] FLD_NS       = 4'd3;
  localparam logic [FIELD_W-1:0] FLD_LON      = 4'd4;
  localparam logic [FIELD_W-1:0] FLD_EW       = 4'd5;
  localparam logic [FIELD_W-1:0] FLD_FIX      = 4'd6;
  localparam logic [FIELD_W-1:0] FLD_MIN_EMIT = 4'd9;

  typedef struct packed {
    logic [WHOLE_W-1:0]    whole;
    logic [FRAC_W_MAX-1:0] frac;
    logic [2:0]            fd;     // 0: no point yet, else 1 + digits kept
    logic [1:0]            chars;  // saturates at 3
    logic                  neg;
  } coord_t;

  typedef struct packed {
    logic [FIX_W-1:0] fix;
    coord_t           lat;
    coord_t           lon;
  } record_t;

  function automatic logic [FRAC_W_MAX-1:0] pow10(input logic [2:0] e);
    logic [FRAC_W_MAX-1:0] v;
    case (e)
      3'd0:    v = 20'd1;
      3'd1:    v = 20'd10;
      3'd2:    v = 20'd100;
      3'd3:    v = 20'd1000;
      3'd4:    v = 20'd10000;
      3'd5:    v = 20'd100000;
      3'd6:    v = 20'd1000000;
      default: v = 20'd0;
    endcase
    return v;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

endpackage

/* rtl/ngga_front.sv */
// Byte parser: line framing, header match, comma fields and number capture.
module ngga_front #(
  parameter int MAX_LINE    = ngga_pkg::MAX_LINE_DEF,
  parameter int FRAC_DIGITS = ngga_pkg::FRAC_DIGITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  output logic                push,
  output ngga_pkg::record_t   rec
);

  localparam int LEN_W = $clog2(MAX_LINE + 1);

  logic [ngga_pkg::FIELD_W-1:0] field_r, field_nxt;
  logic [LEN_W-1:0]             len_r, len_nxt;
  logic [2:0]                   hmp_r, hmp_nxt;
  logic                         good_r, good_nxt;
  logic                         cr_r, cr_nxt;
  logic                         ovf_r, ovf_nxt;
  ngga_pkg::coord_t             lat_r, lat_nxt;
  ngga_pkg::coord_t             lon_r, lon_nxt;
  logic [ngga_pkg::FIX_W-1:0]   fix_r, fix_nxt;
  logic                         stop_r, stop_nxt;

  logic                             line_end;
  logic                             emit;
  logic                             digit;
  logic [ngga_pkg::FIX_EXT_W-1:0]   fix10;

  function automatic logic hdr_char_ok(input logic [2:0] pos, input logic [7:0] b);
    logic ok;
    unique case (pos)
      3'd0:    ok = (b == ngga_pkg::CH_DOLLAR);
      3'd1:    ok = (b == ngga_pkg::CH_G);
      3'd2:    ok = (b == ngga_pkg::CH_P) || (b == ngga_pkg::CH_N);
      3'd3:    ok = (b == ngga_pkg::CH_G);
      3'd4:    ok = (b == ngga_pkg::CH_G);
      3'd5:    ok = (b == ngga_pkg::CH_A);
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  // one character of a coordinate field, number not yet stopped
  function automatic ngga_pkg::coord_t coord_next(input ngga_pkg::coord_t c,
                                                  input logic [7:0] b);
    ngga_pkg::coord_t                o;
    logic [ngga_pkg::WHOLE_EXT_W-1:0] w10;
    logic [ngga_pkg::FRAC_EXT_W-1:0]  f10;
    logic [3:0]                       d;
    o   = c;
    d   = 4'(b - ngga_pkg::CH_ZERO);
    w10 = ngga_pkg::WHOLE_EXT_W'(c.whole) * ngga_pkg::WHOLE_EXT_W'(10)
        + ngga_pkg::WHOLE_EXT_W'(d);
    f10 = ngga_pkg::FRAC_EXT_W'(c.frac) * ngga_pkg::FRAC_EXT_W'(10)
        + ngga_pkg::FRAC_EXT_W'(d);
    if (ngga_pkg::is_digit(b)) begin
      if (c.fd == 3'd0) begin
        o.whole = (w10 > ngga_pkg::WHOLE_EXT_W'(ngga_pkg::WHOLE_MAX)) ?
                  ngga_pkg::WHOLE_MAX : w10[ngga_pkg::WHOLE_W-1:0];
      end else if ((c.fd - 3'd1) < 3'(FRAC_DIGITS)) begin
        o.frac = f10[ngga_pkg::FRAC_W_MAX-1:0];
        o.fd   = c.fd + 3'd1;
      end
    end else if ((b == ngga_pkg::CH_DOT) && (c.fd == 3'd0)) begin
      o.fd = 3'd1;
    end
    return o;
  endfunction

  function automatic logic num_ends(input ngga_pkg::coord_t c, input logic [7:0] b);
    return !ngga_pkg::is_digit(b) && !((b == ngga_pkg::CH_DOT) && (c.fd == 3'd0));
  endfunction

  function automatic logic [1:0] chars_inc(input logic [1:0] ch);
    return (ch == 2'd3) ? ch : ch + 2'd1;
  endfunction

  assign line_end = (data_byte == ngga_pkg::CH_LF) && cr_r;
  assign emit     = !ovf_r && good_r && (field_r >= ngga_pkg::FLD_MIN_EMIT);
  assign push     = accept && line_end && emit;
  assign digit    = ngga_pkg::is_digit(data_byte);
  assign fix10    = ngga_pkg::FIX_EXT_W'(fix_r) * ngga_pkg::FIX_EXT_W'(10)
                  + ngga_pkg::FIX_EXT_W'(data_byte - ngga_pkg::CH_ZERO);

  assign rec.fix = fix_r;
  assign rec.lat = lat_r;
  assign rec.lon = lon_r;

  always_comb begin
    field_nxt = field_r;
    len_nxt   = len_r;
    hmp_nxt   = hmp_r;
    good_nxt  = good_r;
    cr_nxt    = cr_r;
    ovf_nxt   = ovf_r;
    lat_nxt   = lat_r;
    lon_nxt   = lon_r;
    fix_nxt   = fix_r;
    stop_nxt  = stop_r;
    if (accept) begin
      if (line_end) begin
        field_nxt = '0;
        len_nxt   = '0;
        hmp_nxt   = '0;
        good_nxt  = 1'b0;
        cr_nxt    = 1'b0;
        ovf_nxt   = 1'b0;
        lat_nxt   = '0;
        lon_nxt   = '0;
        fix_nxt   = '0;
        stop_nxt  = 1'b0;
      end else begin
        // a CR that may start the line end does not count as overflow
        if (len_r < LEN_W'(MAX_LINE)) begin
          len_nxt = len_r + LEN_W'(1);
        end else if (!((data_byte == ngga_pkg::CH_CR) && !cr_r)) begin
          ovf_nxt = 1'b1;
        end
        cr_nxt = (data_byte == ngga_pkg::CH_CR);

        if ((len_r < LEN_W'(ngga_pkg::HDR_LEN)) && (LEN_W'(hmp_r) == len_r) &&
            hdr_char_ok(len_r[2:0], data_byte)) begin
          hmp_nxt = hmp_r + 3'd1;
        end
        if ((len_r == LEN_W'(ngga_pkg::HDR_LEN)) && (hmp_r == 3'(ngga_pkg::HDR_LEN)) &&
            (data_byte == ngga_pkg::CH_COMMA)) begin
          good_nxt = 1'b1;
        end

        if (data_byte == ngga_pkg::CH_COMMA) begin
          if (field_r < ngga_pkg::FIELD_W'(ngga_pkg::MAX_FIELDS - 1)) begin
            field_nxt = field_r + 4'd1;
          end
          stop_nxt = 1'b0;
        end else begin
          unique case (field_r)
            ngga_pkg::FLD_LAT: begin
              lat_nxt.chars = chars_inc(lat_r.chars);
              if (!stop_r) begin
                lat_nxt  = coord_next(lat_r, data_byte);
                lat_nxt.chars = chars_inc(lat_r.chars);
                stop_nxt = num_ends(lat_r, data_byte);
              end
            end
            ngga_pkg::FLD_NS: begin
              if (!stop_r) begin
                lat_nxt.neg = (data_byte == ngga_pkg::CH_S);
                stop_nxt    = 1'b1;
              end
            end
            ngga_pkg::FLD_LON: begin
              lon_nxt.chars = chars_inc(lon_r.chars);
              if (!stop_r) begin
                lon_nxt  = coord_next(lon_r, data_byte);
                lon_nxt.chars = chars_inc(lon_r.chars);
                stop_nxt = num_ends(lon_r, data_byte);
              end
            end
            ngga_pkg::FLD_EW: begin
              if (!stop_r) begin
                lon_nxt.neg = (data_byte == ngga_pkg::CH_W);
                stop_nxt    = 1'b1;
              end
            end
            ngga_pkg::FLD_FIX: begin
              if (!stop_r) begin
                if (digit) begin
                  fix_nxt = (fix10 > ngga_pkg::FIX_EXT_W'(ngga_pkg::FIX_MAX)) ?
                            ngga_pkg::FIX_MAX : fix10[ngga_pkg::FIX_W-1:0];
                end else begin
                  stop_nxt = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_r <= '0;
      len_r   <= '0;
      hmp_r   <= '0;
      good_r  <= 1'b0;
      cr_r    <= 1'b0;
      ovf_r   <= 1'b0;
      lat_r   <= '0;
      lon_r   <= '0;
      fix_r   <= '0;
      stop_r  <= 1'b0;
    end else begin
      field_r <= field_nxt;
      len_r   <= len_nxt;
      hmp_r   <= hmp_nxt;
      good_r  <= good_nxt;
      cr_r    <= cr_nxt;
      ovf_r   <= ovf_nxt;
      lat_r   <= lat_nxt;
      lon_r   <= lon_nxt;
      fix_r   <= fix_nxt;
      stop_r  <= stop_nxt;
    end
  end

endmodule

/* rtl/ngga_queue.sv */
// Short record queue between the byte parser and the converter.
module ngga_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ngga_pkg::record_t push_data,
  output logic              has_room,
  output logic              pop_valid,
  input  logic              pop_ready,
  output ngga_pkg::record_t pop_data
);

  localparam int DEPTH = ngga_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  ngga_pkg::record_t mem_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              pop;

  assign has_room  = (cnt_r < CW'(DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !has_room |-> !push)
    else $error("record pushed into full queue");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with empty count");

endmodule

/* rtl/ngga_conv.sv */
// Pipelined ddmm.mmmm to signed degrees*1e7 converter, constant divides by reciprocal.
module ngga_conv #(
  parameter int FRAC_DIGITS = ngga_pkg::FRAC_DIGITS_DEF,
  parameter int OUT_W       = ngga_pkg::LAT_W,
  parameter int LIMIT       = ngga_pkg::LAT_LIMIT
) (
  input  logic                    clk,
  input  logic                    en,
  input  ngga_pkg::coord_t        c,
  input  logic                    zero,
  output logic signed [OUT_W-1:0] value
);

  localparam int UNIT    = 10 ** FRAC_DIGITS;
  localparam int SCALE_M = 10 ** (7 - FRAC_DIGITS);
  localparam int FSC_W   = $clog2(UNIT);
  localparam int MIN_W   = $clog2(100 * UNIT);
  localparam int PFR_W   = ngga_pkg::FRAC_W_MAX + 20;

  // stage 1
  logic [29:0]                  p100;
  logic [2:0]                   kept;
  logic [2:0]                   pexp;
  logic [PFR_W-1:0]             pfr;
  logic [ngga_pkg::WHOLE_W-1:0] w1_r;
  logic [10:0]                  q0_r;
  logic [FSC_W-1:0]             fsc1_r;
  logic                         ok1_r, neg1_r;
  // stage 2
  logic [17:0]                  r0;
  logic                         r0_ge;
  logic [10:0]                  q2_r;
  logic [6:0]                   r2_r;
  logic [FSC_W-1:0]             fsc2_r;
  logic                         ok2_r, neg2_r;
  // stage 3
  logic [29:0]                  min_sum;
  logic [MIN_W-1:0]             min3_r;
  logic [33:0]                  qdeg3_r;
  logic                         ok3_r, neg3_r;
  // stage 4
  logic [29:0]                  x4;
  logic [27:0]                  y4_r;
  logic [33:0]                  qdeg4_r;
  logic                         ok4_r, neg4_r;
  // stage 5
  logic [56:0]                  p15;
  logic [27:0]                  y5_r;
  logic [24:0]                  q15_r;
  logic [33:0]                  qdeg5_r;
  logic                         ok5_r, neg5_r;
  // stage 6
  logic [27:0]                  r15;
  logic [24:0]                  mt6_r;
  logic [33:0]                  qdeg6_r;
  logic                         ok6_r, neg6_r;
  // stage 7
  logic [34:0]                  mag;
  logic [OUT_W-1:0]             mag7_r;
  logic                         ok7_r, neg7_r;
  // stage 8
  logic [OUT_W-1:0]             value_r;

  always_comb begin
    kept = (c.fd == 3'd0) ? 3'd0 : c.fd - 3'd1;
    pexp = 3'(FRAC_DIGITS) - kept;
  end

  assign p100 = 30'(c.whole) * 30'(ngga_pkg::RECIP100);
  assign pfr  = PFR_W'(c.frac) * PFR_W'(ngga_pkg::pow10(pexp));

  // quotient estimate is at most one low
  assign r0    = 18'(w1_r) - 18'(q0_r) * 18'd100;
  assign r0_ge = (r0 >= 18'd100);

  assign min_sum = 30'(r2_r) * 30'(UNIT) + 30'(fsc2_r);

  // minutes*1e7/60 rounded half up: floor((min*M + 30) / 60), /4 then /15
  assign x4  = 30'(min3_r) * 30'(SCALE_M) + 30'd30;
  assign p15 = 57'(y4_r) * 57'(ngga_pkg::RECIP15);
  assign r15 = y5_r - 28'(q15_r) * 28'd15;
  assign mag = 35'(qdeg6_r) + 35'(mt6_r);

  always_ff @(posedge clk) begin
    if (en) begin
      w1_r    <= c.whole;
      q0_r    <= p100[29:19];
      fsc1_r  <= pfr[FSC_W-1:0];
      ok1_r   <= (c.chars == 2'd3) && !zero;
      neg1_r  <= c.neg;

      q2_r    <= q0_r + 11'(r0_ge);
      r2_r    <= r0_ge ? 7'(r0 - 18'd100) : r0[6:0];
      fsc2_r  <= fsc1_r;
      ok2_r   <= ok1_r;
      neg2_r  <= neg1_r;

      min3_r  <= min_sum[MIN_W-1:0];
      qdeg3_r <= 34'(q2_r) * 34'd10000000;
      ok3_r   <= ok2_r;
      neg3_r  <= neg2_r;

      y4_r    <= x4[29:2];
      qdeg4_r <= qdeg3_r;
      ok4_r   <= ok3_r;
      neg4_r  <= neg3_r;

      y5_r    <= y4_r;
      q15_r   <= p15[56:32];
      qdeg5_r <= qdeg4_r;
      ok5_r   <= ok4_r;
      neg5_r  <= neg4_r;

      mt6_r   <= q15_r + 25'(r15 >= 28'd15);
      qdeg6_r <= qdeg5_r;
      ok6_r   <= ok5_r;
      neg6_r  <= neg5_r;

      mag7_r  <= (mag > 35'(LIMIT)) ? OUT_W'(LIMIT) : mag[OUT_W-1:0];
      ok7_r   <= ok6_r;
      neg7_r  <= neg6_r;

      value_r <= !ok7_r ? '0 : (neg7_r ? OUT_W'(0) - mag7_r : mag7_r);
    end
  end

  assign value = $signed(value_r);

endmodule

/* rtl/ngga_back.sv */
// Conversion back end: two coordinate lanes, fix pipeline and result register.
module ngga_back #(
  parameter int FRAC_DIGITS = ngga_pkg::FRAC_DIGITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                rec_valid,
  input  ngga_pkg::record_t                   rec,
  output logic                                rec_ready,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_fix_valid,
  output logic [ngga_pkg::FIX_W-1:0]          out_fix_quality,
  output logic signed [ngga_pkg::LAT_W-1:0]   out_latitude_e7,
  output logic signed [ngga_pkg::LON_W-1:0]   out_longitude_e7
);

  localparam int NS = ngga_pkg::CONV_STAGES;

  logic [NS-1:0]              vld_r;
  logic [ngga_pkg::FIX_W-1:0] fix_r [NS];
  logic                       advance;
  logic                       no_fix;

  // whole pipeline holds while a result waits
  assign advance   = !vld_r[NS-1] || out_ready;
  assign rec_ready = advance;
  assign no_fix    = (rec.fix == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (advance) begin
      vld_r <= {vld_r[NS-2:0], rec_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fix_r[0] <= rec.fix;
      for (int i = 1; i < NS; i++) begin
        fix_r[i] <= fix_r[i-1];
      end
    end
  end

  ngga_conv #(
    .FRAC_DIGITS (FRAC_DIGITS),
    .OUT_W       (ngga_pkg::LAT_W),
    .LIMIT       (ngga_pkg::LAT_LIMIT)
  ) u_lat (
    .clk   (clk),
    .en    (advance),
    .c     (rec.lat),
    .zero  (no_fix),
    .value (out_latitude_e7)
  );

  ngga_conv #(
    .FRAC_DIGITS (FRAC_DIGITS),
    .OUT_W       (ngga_pkg::LON_W),
    .LIMIT       (ngga_pkg::LON_LIMIT)
  ) u_lon (
    .clk   (clk),
    .en    (advance),
    .c     (rec.lon),
    .zero  (no_fix),
    .value (out_longitude_e7)
  );

  assign out_valid       = vld_r[NS-1];
  assign out_fix_quality = fix_r[NS-1];
  assign out_fix_valid   = (fix_r[NS-1] != '0);

  a_nofix_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_fix_valid) |->
      (out_latitude_e7 == '0) && (out_longitude_e7 == '0))
    else $error("coordinates nonzero without fix");

  a_lat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_latitude_e7 <= ngga_pkg::LAT_LIMIT) &&
                  (out_latitude_e7 >= -ngga_pkg::LAT_LIMIT))
    else $error("latitude out of range");

endmodule

/* rtl/nmea_gga_position_parser_core.sv */
// A line's record enters the queue at the transfer of the LF that ends it, then passes the converter.
// One byte per cycle while in_ready is high; the 8-stage converter takes a new record every cycle unless held.
// in_ready drops while the two-entry record queue is full, even in a cycle its head is taken.
// out_valid holds the converter pipeline (and the queue behind it) while stalled.
// Reset (synchronous, rst_n low) clears the line state, the queue and the pipeline valids.
module nmea_gga_position_parser_core #(
  parameter int MAX_LINE    = ngga_pkg::MAX_LINE_DEF,
  parameter int FRAC_DIGITS = ngga_pkg::FRAC_DIGITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          in_data_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_fix_valid,
  output logic [ngga_pkg::FIX_W-1:0]          out_fix_quality,
  output logic signed [ngga_pkg::LAT_W-1:0]   out_latitude_e7,
  output logic signed [ngga_pkg::LON_W-1:0]   out_longitude_e7
);

  logic              accept;
  logic              push;
  ngga_pkg::record_t push_rec;
  logic              has_room;
  logic              q_valid;
  logic              q_ready;
  ngga_pkg::record_t q_rec;

  assign in_ready = has_room;
  assign accept   = in_valid && in_ready;

  ngga_front #(
    .MAX_LINE    (MAX_LINE),
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_data_byte),
    .push      (push),
    .rec       (push_rec)
  );

  ngga_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_rec),
    .has_room  (has_room),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_data  (q_rec)
  );

  ngga_back #(
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .rec_valid        (q_valid),
    .rec              (q_rec),
    .rec_ready        (q_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_fix_valid    (out_fix_valid),
    .out_fix_quality  (out_fix_quality),
    .out_latitude_e7  (out_latitude_e7),
    .out_longitude_e7 (out_longitude_e7)
  );

endmodule
